>>> hdl/phc_pkg.sv
`default_nettype none
package phc_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // Q.16 plane distance: 18x32 products plus the shifted offset
  localparam int DIST_W = 53;
  localparam int NPROD_W = 50;
  // crossing arithmetic
  localparam int DLT_W = 33;                 // |curr - prev|
  localparam int DEN_W = DIST_W + 1;         // |dprev - dcurr|
  localparam int PROD_W = DIST_W + DLT_W;    // |dprev| * |delta|
  localparam int MUL_STEPS = DLT_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int IT_W = $clog2(DIV_STEPS);

  localparam logic [17:0] NX_RESET = 18'd65536;
  localparam logic [17:0] NY_RESET = 18'd0;
  localparam logic [31:0] C_RESET = 32'd0;
  localparam logic [15:0] EPS_RESET = 16'd1;

  typedef enum logic [1:0] {
    REG_NORMAL_X     = 2'd0,
    REG_NORMAL_Y     = 2'd1,
    REG_PLANE_OFFSET = 2'd2,
    REG_NEAR_EPSILON = 2'd3
  } phc_reg_idx_t;

  typedef struct packed {
    logic signed [31:0] vertex_x;
    logic signed [31:0] vertex_y;
    logic               final_vertex;
  } phc_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               last_of_run;
    logic               clipped_empty;
    logic               vertex_overflow;
  } phc_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } phc_pt_t;

  // crossing unit: one coordinate of prev + dprev*(curr-prev)/(dprev-dcurr)
  typedef struct packed {
    logic                     start;
    logic signed [31:0]       pa;
    logic signed [31:0]       pb;
    logic signed [DIST_W-1:0] dp;
    logic signed [DIST_W-1:0] dc;
  } phc_xreq_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] coord;
  } phc_xrsp_t;

  typedef struct packed {
    logic        start;
    phc_pt_t     a;
    phc_pt_t     b;
    logic [15:0] eps;
  } phc_nreq_t;

  typedef struct packed {
    logic done;
    logic is_near;
  } phc_nrsp_t;

  typedef enum logic [2:0] {
    MD_IDLE, MD_MUL, MD_DIV, MD_RND, MD_SAT
  } phc_md_state_t;

  typedef enum logic [1:0] {
    NR_IDLE, NR_SQX, NR_SQY, NR_EPS
  } phc_nr_state_t;

  typedef enum logic [4:0] {
    ST_LOAD, ST_FETCH, ST_LATCH, ST_DIST2, ST_DIST3, ST_EDGE,
    ST_XSTART, ST_XWAIT, ST_YSTART, ST_YWAIT, ST_CAND, ST_NWAIT,
    ST_PUSH, ST_NEXT, ST_FIN, ST_FNWAIT, ST_EMIT_P1, ST_EMIT_P2,
    ST_EMIT_P1L, ST_EMIT_EMPTY
  } phc_state_t;

endpackage
`default_nettype wire

>>> hdl/phc_muldiv.sv
`default_nettype none
module phc_muldiv (
  input  wire                clk,
  input  wire                rst_n,
  input  phc_pkg::phc_xreq_t req,
  output phc_pkg::phc_xrsp_t rsp
);
  import phc_pkg::*;

  phc_md_state_t st_r, st_nxt;
  logic [IT_W-1:0]   it_r;
  logic signed [31:0] pa_r;
  logic              neg_r;
  logic              den_zero_r;
  logic [DEN_W-1:0]  den_r;
  logic [PROD_W-1:0] mcand_r;
  logic [DLT_W-1:0]  mplier_r;
  logic [PROD_W-1:0] acc_r;      // product, then dividend/quotient
  logic [DEN_W:0]    rem_r;
  logic [PROD_W:0]   qr_r;
  logic signed [31:0] res_r;
  logic              done_r;

  logic signed [DLT_W-1:0] delta;
  logic signed [DEN_W-1:0] dd;
  logic [DIST_W-1:0]       amag;
  logic [DLT_W-1:0]        bmag;
  logic [DEN_W-1:0]        dmag;
  logic [DEN_W:0]          rem_sh;
  logic                    ge;
  logic                    rnd;
  logic signed [36:0]      sum;

  always_comb begin
    delta  = DLT_W'(req.pb) - DLT_W'(req.pa);
    dd     = DEN_W'(req.dp) - DEN_W'(req.dc);
    amag   = req.dp[DIST_W-1] ? DIST_W'(-req.dp) : DIST_W'(req.dp);
    bmag   = delta[DLT_W-1] ? DLT_W'(-delta) : DLT_W'(delta);
    dmag   = dd[DEN_W-1] ? DEN_W'(-dd) : DEN_W'(dd);
    rem_sh = {rem_r[DEN_W-1:0], acc_r[PROD_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
    rnd    = {rem_r, 1'b0} >= {2'b00, den_r};
    sum    = neg_r ? 37'(pa_r) - 37'({2'b00, qr_r[34:0]})
                   : 37'(pa_r) + 37'({2'b00, qr_r[34:0]});
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      MD_IDLE: if (req.start) st_nxt = MD_MUL;
      MD_MUL:  if (it_r == IT_W'(MUL_STEPS - 1)) st_nxt = MD_DIV;
      MD_DIV:  if (it_r == IT_W'(DIV_STEPS - 1)) st_nxt = MD_RND;
      MD_RND:  st_nxt = MD_SAT;
      MD_SAT:  st_nxt = MD_IDLE;
      default: st_nxt = MD_IDLE;
    endcase
  end

  always_comb begin
    rsp.done  = done_r;
    rsp.coord = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= MD_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == MD_SAT);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      MD_IDLE: begin
        pa_r       <= req.pa;
        neg_r      <= req.dp[DIST_W-1] ^ delta[DLT_W-1] ^ dd[DEN_W-1];
        den_r      <= dmag;
        den_zero_r <= (dmag == '0);
        mcand_r    <= PROD_W'(amag);
        mplier_r   <= bmag;
        acc_r      <= '0;
        rem_r      <= '0;
        it_r       <= '0;
      end
      MD_MUL: begin
        if (mplier_r[0]) acc_r <= acc_r + mcand_r;
        mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[DLT_W-1:1]};
        it_r     <= (it_r == IT_W'(MUL_STEPS - 1)) ? '0 : it_r + 1'b1;
      end
      MD_DIV: begin
        rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
        acc_r <= {acc_r[PROD_W-2:0], ge};
        it_r  <= it_r + 1'b1;
      end
      MD_RND: qr_r <= {1'b0, acc_r} + (PROD_W + 1)'(rnd);
      MD_SAT: begin
        if (den_zero_r) res_r <= pa_r;
        else if (qr_r > (PROD_W + 1)'(35'h4_0000_0000))
          res_r <= neg_r ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (sum > 37'sh0_7FFF_FFFF) res_r <= 32'sh7FFF_FFFF;
        else if (sum < -37'sh0_8000_0000) res_r <= 32'sh8000_0000;
        else res_r <= sum[31:0];
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/phc_near.sv
`default_nettype none
module phc_near (
  input  wire                clk,
  input  wire                rst_n,
  input  phc_pkg::phc_nreq_t req,
  output phc_pkg::phc_nrsp_t rsp
);
  import phc_pkg::*;

  phc_nr_state_t st_r, st_nxt;
  logic [32:0] dx_r, dy_r;
  logic        far_r;
  logic [15:0] eps_r;
  logic [32:0] acc_r;
  logic        near_r;
  logic        done_r;

  logic signed [32:0] sdx, sdy;
  logic [32:0]        mdx, mdy;
  logic [15:0]        mul_a;
  logic [31:0]        mul_p;

  always_comb begin
    sdx = 33'(req.a.x) - 33'(req.b.x);
    sdy = 33'(req.a.y) - 33'(req.b.y);
    mdx = sdx[32] ? 33'(-sdx) : 33'(sdx);
    mdy = sdy[32] ? 33'(-sdy) : 33'(sdy);
    unique case (st_r)
      NR_SQY:  mul_a = dy_r[15:0];
      NR_EPS:  mul_a = eps_r;
      default: mul_a = dx_r[15:0];
    endcase
    mul_p = mul_a * mul_a;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      NR_IDLE: if (req.start) st_nxt = NR_SQX;
      NR_SQX:  st_nxt = NR_SQY;
      NR_SQY:  st_nxt = NR_EPS;
      NR_EPS:  st_nxt = NR_IDLE;
      default: st_nxt = NR_IDLE;
    endcase
  end

  always_comb begin
    rsp.done    = done_r;
    rsp.is_near = near_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= NR_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == NR_EPS);
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      NR_IDLE: begin
        dx_r  <= mdx;
        dy_r  <= mdy;
        far_r <= (mdx >= 33'(req.eps)) || (mdy >= 33'(req.eps));
        eps_r <= req.eps;
      end
      NR_SQX: acc_r <= 33'(mul_p);
      NR_SQY: acc_r <= acc_r + 33'(mul_p);
      NR_EPS: near_r <= !far_r && (acc_r < 33'(mul_p));
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/polygon_halfplane_clipper_core.sv
// Channel | Dir | Ports                           | Transfer when
// input   | in  | in_valid, in_stall, in_data     | in_valid && !in_stall
// result  | out | out_valid, out_stall, out_data  | out_valid && !out_stall
// config  | in  | cfg_we, cfg_index, cfg_wdata    | cfg_we
//
// A non-final vertex is taken without a stall. After the final vertex the block stalls
// its input while it walks the store: the closing vertex first, then each vertex with its
// plane distance, a bit-serial multiply/divide per crossing coordinate (33 + 86 steps per
// coordinate) and a proximity check for candidate points, then the last results flush.
// rst_n is synchronous; it restores register defaults and empties the store.
// A result waits in the output register while out_stall is high.
`default_nettype none
module polygon_halfplane_clipper_core (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  phc_pkg::phc_in_t   in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output phc_pkg::phc_out_t  out_data,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_index,
  input  wire  [31:0]        cfg_wdata
);
  import phc_pkg::*;

  phc_state_t st_r, st_nxt;

  logic signed [17:0] nx_r, ny_r;
  logic signed [31:0] c_r;
  logic [15:0]        eps_r;

  phc_pt_t            mem [MAX_VERTICES];
  phc_pt_t            rdata_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic [CNT_W-1:0]   count_r;
  logic               ovf_r;
  logic [IDX_W-1:0]   i_r;
  logic               pass_prev_r;

  phc_pt_t                  cur_r, prev_r, cand_r, p1_r, p2_r, first_r;
  logic signed [DIST_W-1:0] cur_d_r, prev_d_r, acc_r;
  logic signed [NPROD_W-1:0] prod_r;
  logic                     ci_r, cand_cross_r;
  logic [1:0]               cnt_r;   // points kept: 0, 1, or 2 and more

  phc_out_t out_r;
  logic     out_valid_r;

  phc_xreq_t xreq;
  phc_xrsp_t xrsp;
  phc_nreq_t nreq;
  phc_nrsp_t nrsp;

  logic                      in_xfer, full, slot_free, ci, pi, last_i, more_cur;
  logic signed [17:0]        mul_a;
  logic signed [31:0]        mul_b;
  logic signed [DIST_W-1:0]  c_ext, lim, dist_sum;

  phc_muldiv u_muldiv (.clk(clk), .rst_n(rst_n), .req(xreq), .rsp(xrsp));
  phc_near   u_near   (.clk(clk), .rst_n(rst_n), .req(nreq), .rsp(nrsp));

  always_comb begin
    in_xfer   = in_valid && !in_stall;
    full      = (count_r == CNT_W'(MAX_VERTICES));
    slot_free = !out_valid_r || !out_stall;
    c_ext     = {{(DIST_W - 48){c_r[31]}}, c_r, 16'h0000};
    lim       = $signed({{(DIST_W - 32){1'b0}}, eps_r, 16'h0000});
    dist_sum  = acc_r + DIST_W'(prod_r);
    ci        = cur_d_r <= lim;
    pi        = prev_d_r <= lim;
    last_i    = (CNT_W'(i_r) + CNT_W'(1)) == count_r;
    more_cur  = cand_cross_r && ci_r;
    mul_a     = (st_r == ST_LATCH) ? nx_r : ny_r;
    mul_b     = (st_r == ST_LATCH) ? rdata_r.x : cur_r.y;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_LOAD:   if (in_xfer && in_data.final_vertex) st_nxt = ST_FETCH;
      ST_FETCH:  st_nxt = ST_LATCH;
      ST_LATCH:  st_nxt = ST_DIST2;
      ST_DIST2:  st_nxt = ST_DIST3;
      ST_DIST3:  st_nxt = pass_prev_r ? ST_FETCH : ST_EDGE;
      ST_EDGE: begin
        if (ci != pi) st_nxt = ST_XSTART;
        else if (ci)  st_nxt = ST_CAND;
        else          st_nxt = ST_NEXT;
      end
      ST_XSTART: st_nxt = ST_XWAIT;
      ST_XWAIT:  if (xrsp.done) st_nxt = ST_YSTART;
      ST_YSTART: st_nxt = ST_YWAIT;
      ST_YWAIT:  if (xrsp.done) st_nxt = ST_CAND;
      ST_CAND:   st_nxt = (cnt_r == 2'd0) ? ST_PUSH : ST_NWAIT;
      ST_NWAIT: begin
        if (nrsp.done) begin
          if (!nrsp.is_near) st_nxt = ST_PUSH;
          else               st_nxt = more_cur ? ST_CAND : ST_NEXT;
        end
      end
      ST_PUSH: begin
        if (cnt_r != 2'd2 || slot_free) st_nxt = more_cur ? ST_CAND : ST_NEXT;
      end
      ST_NEXT:   st_nxt = last_i ? ST_FIN : ST_FETCH;
      ST_FIN: begin
        unique case (cnt_r)
          2'd0:    st_nxt = ST_EMIT_EMPTY;
          2'd1:    st_nxt = ST_EMIT_P2;
          default: st_nxt = ST_FNWAIT;
        endcase
      end
      ST_FNWAIT: if (nrsp.done) st_nxt = nrsp.is_near ? ST_EMIT_P1L : ST_EMIT_P1;
      ST_EMIT_P1: if (slot_free) st_nxt = ST_EMIT_P2;
      ST_EMIT_P2, ST_EMIT_P1L, ST_EMIT_EMPTY: if (slot_free) st_nxt = ST_LOAD;
      default: st_nxt = ST_LOAD;
    endcase
  end

  // unit requests and handshake outputs
  always_comb begin
    in_stall   = (st_r != ST_LOAD);
    out_valid  = out_valid_r;
    out_data   = out_r;
    xreq.start = (st_r == ST_XSTART) || (st_r == ST_YSTART);
    xreq.pa    = (st_r == ST_YSTART) ? prev_r.y : prev_r.x;
    xreq.pb    = (st_r == ST_YSTART) ? cur_r.y : cur_r.x;
    xreq.dp    = prev_d_r;
    xreq.dc    = cur_d_r;
    nreq.start = ((st_r == ST_CAND) && (cnt_r != 2'd0)) ||
                 ((st_r == ST_FIN) && (cnt_r == 2'd2));
    nreq.a     = (st_r == ST_FIN) ? first_r : p2_r;
    nreq.b     = (st_r == ST_FIN) ? p2_r : cand_r;
    nreq.eps   = eps_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r  <= NX_RESET;
      ny_r  <= NY_RESET;
      c_r   <= C_RESET;
      eps_r <= EPS_RESET;
    end else if (cfg_we) begin
      unique case (phc_reg_idx_t'(cfg_index))
        REG_NORMAL_X:     nx_r  <= cfg_wdata[17:0];
        REG_NORMAL_Y:     ny_r  <= cfg_wdata[17:0];
        REG_PLANE_OFFSET: c_r   <= cfg_wdata;
        REG_NEAR_EPSILON: eps_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // vertex store
  always_ff @(posedge clk) begin
    if (in_xfer && !full) begin
      mem[count_r[IDX_W-1:0]] <= '{x: in_data.vertex_x, y: in_data.vertex_y};
    end
    rdata_r <= mem[rd_idx_r];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= 2'd0;
    end else begin
      st_r <= st_nxt;
      if (in_xfer) begin
        if (full) ovf_r <= 1'b1;
        else      count_r <= count_r + 1'b1;
      end
      if (st_r == ST_LOAD && in_xfer && in_data.final_vertex) cnt_r <= 2'd0;
      if (st_r == ST_PUSH && st_nxt != ST_PUSH && cnt_r != 2'd2) cnt_r <= cnt_r + 1'b1;
      if ((st_r == ST_EMIT_P2 || st_r == ST_EMIT_P1L || st_r == ST_EMIT_EMPTY) && slot_free) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end
      if ((st_r == ST_PUSH && cnt_r == 2'd2 && slot_free) ||
          ((st_r == ST_EMIT_P1 || st_r == ST_EMIT_P2 || st_r == ST_EMIT_P1L ||
            st_r == ST_EMIT_EMPTY) && slot_free)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_LOAD: begin
        rd_idx_r    <= full ? IDX_W'(MAX_VERTICES - 1) : count_r[IDX_W-1:0];
        i_r         <= '0;
        pass_prev_r <= 1'b1;
      end
      ST_LATCH: begin
        cur_r  <= rdata_r;
        prod_r <= NPROD_W'(mul_a * mul_b);
      end
      ST_DIST2: begin
        acc_r  <= DIST_W'(prod_r) - c_ext;
        prod_r <= NPROD_W'(mul_a * mul_b);
      end
      ST_DIST3: begin
        if (pass_prev_r) begin
          prev_r      <= cur_r;
          prev_d_r    <= dist_sum;
          pass_prev_r <= 1'b0;
          rd_idx_r    <= '0;
        end else begin
          cur_d_r <= dist_sum;
        end
      end
      ST_EDGE: begin
        ci_r         <= ci;
        cand_cross_r <= (ci != pi);
        if (ci == pi) cand_r <= cur_r;
      end
      ST_XWAIT: if (xrsp.done) cand_r.x <= xrsp.coord;
      ST_YWAIT: if (xrsp.done) cand_r.y <= xrsp.coord;
      ST_NWAIT: begin
        if (nrsp.done && nrsp.is_near && more_cur) begin
          cand_r       <= cur_r;
          cand_cross_r <= 1'b0;
        end
      end
      ST_PUSH: begin
        if (cnt_r != 2'd2 || slot_free) begin
          if (cnt_r == 2'd0) first_r <= cand_r;
          if (cnt_r == 2'd2) out_r <= '{out_x: p1_r.x, out_y: p1_r.y, last_of_run: 1'b0,
                                        clipped_empty: 1'b0, vertex_overflow: ovf_r};
          p1_r <= p2_r;
          p2_r <= cand_r;
          if (more_cur) begin
            cand_r       <= cur_r;
            cand_cross_r <= 1'b0;
          end
        end
      end
      ST_NEXT: begin
        prev_r   <= cur_r;
        prev_d_r <= cur_d_r;
        i_r      <= i_r + 1'b1;
        rd_idx_r <= i_r + 1'b1;
      end
      ST_EMIT_P1: if (slot_free) out_r <= '{out_x: p1_r.x, out_y: p1_r.y, last_of_run: 1'b0,
                                             clipped_empty: 1'b0, vertex_overflow: ovf_r};
      ST_EMIT_P2: if (slot_free) out_r <= '{out_x: p2_r.x, out_y: p2_r.y, last_of_run: 1'b1,
                                             clipped_empty: 1'b0, vertex_overflow: ovf_r};
      ST_EMIT_P1L: if (slot_free) out_r <= '{out_x: p1_r.x, out_y: p1_r.y, last_of_run: 1'b1,
                                              clipped_empty: 1'b0, vertex_overflow: ovf_r};
      ST_EMIT_EMPTY: if (slot_free) out_r <= '{out_x: 32'sd0, out_y: 32'sd0,
                                                last_of_run: 1'b1, clipped_empty: 1'b1,
                                                vertex_overflow: ovf_r};
      default: ;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.clipped_empty |-> out_r.last_of_run)
    else $error("empty marker without end of run");

  a_final_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_data.final_vertex |=> in_stall)
    else $error("input taken while clipping");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(xreq.start && nreq.start))
    else $error("both units started together");

  a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_NEXT |-> CNT_W'(i_r) < count_r)
    else $error("walk index past vertex count");

endmodule
`default_nettype wire
